// File: rtl/dtl_pkg.sv
// Shared types, microcode codes and byte-formatting functions for the DER header encoder.
package dtl_pkg;

    localparam int TagW  = 32;
    localparam int ClenW = 32;
    localparam int HlenW = ClenW + 1;   // explicit outer length may carry past 32 bits
    localparam int IdxW  = 3;           // byte index within a tag or length field, up to 4
    localparam int NiW   = 4;           // inner header length, up to 11
    localparam int StepW = 3;

    localparam logic [1:0] MODE_IMPLICIT = 2'd1;
    localparam logic [1:0] MODE_EXPLICIT = 2'd2;
    localparam logic [1:0] CLASS_CONTEXT = 2'd2;

    localparam logic [TagW-1:0] TAG_SHORT_MAX = 32'd30;
    localparam logic [4:0]      TAG_LONG_ID   = 5'h1f;
    localparam logic [7:0]      LEN_LONG_FLAG = 8'h80;
    localparam logic [7:0]      TAG_MORE_FLAG = 8'h80;

    typedef struct packed {
        logic [1:0]       tag_class;
        logic             constructed;
        logic [TagW-1:0]  tag_number;
        logic [ClenW-1:0] content_length;
        logic [1:0]       tag_mode;
        logic [TagW-1:0]  override_tag;
    } t_in;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } t_out;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_PREP,
        OP_ID,
        OP_TAG,
        OP_LENHDR,
        OP_LENBYTE,
        OP_SWITCH
    } t_op;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_SHORT_TAG,
        COND_IDX_ZERO,
        COND_SHORT_LEN,
        COND_OUTER
    } t_cond;

    typedef logic [StepW-1:0] t_step;

    localparam t_step STEP_IDLE    = 3'd0;
    localparam t_step STEP_PREP    = 3'd1;
    localparam t_step STEP_ID      = 3'd2;
    localparam t_step STEP_TAG     = 3'd3;
    localparam t_step STEP_LENHDR  = 3'd4;
    localparam t_step STEP_LENBYTE = 3'd5;
    localparam t_step STEP_SWITCH  = 3'd6;

    // One control word: operation, branch condition, taken and not-taken targets.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctl;

    typedef struct packed {
        logic short_tag;
        logic short_len;
        logic idx_zero;
        logic outer;
        logic out_busy;
    } t_stat;

    // Number of base-128 groups in a tag.
    function automatic logic [IdxW-1:0] tag_groups(input logic [TagW-1:0] t);
        logic [IdxW-1:0] g;
        if (|t[31:28]) g = 3'd5;
        else if (|t[27:21]) g = 3'd4;
        else if (|t[20:14]) g = 3'd3;
        else if (|t[13:7]) g = 3'd2;
        else g = 3'd1;
        return g;
    endfunction

    // Number of significant bytes in a length.
    function automatic logic [IdxW-1:0] len_bytes(input logic [HlenW-1:0] l);
        logic [IdxW-1:0] n;
        if (l[32]) n = 3'd5;
        else if (|l[31:24]) n = 3'd4;
        else if (|l[23:16]) n = 3'd3;
        else if (|l[15:8]) n = 3'd2;
        else n = 3'd1;
        return n;
    endfunction

    function automatic logic [7:0] tag_byte(input logic [TagW-1:0] t,
                                            input logic [IdxW-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = {1'b0, t[6:0]};
            3'd1: b = TAG_MORE_FLAG | {1'b0, t[13:7]};
            3'd2: b = TAG_MORE_FLAG | {1'b0, t[20:14]};
            3'd3: b = TAG_MORE_FLAG | {1'b0, t[27:21]};
            3'd4: b = TAG_MORE_FLAG | {4'b0000, t[31:28]};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] len_byte(input logic [HlenW-1:0] l,
                                            input logic [IdxW-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = l[7:0];
            3'd1: b = l[15:8];
            3'd2: b = l[23:16];
            3'd3: b = l[31:24];
            3'd4: b = {7'b0000000, l[32]};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/der_tag_length_header_encoder_top.sv
// Sequence: take the element, size the headers, then one word per cycle unless the output stalls;
// each header ends with a switch step that emits no word; the longest explicit header is 23 bytes.
// One element at a time: the microprogram step counter returns to idle before the next is taken.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output register.
module der_tag_length_header_encoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dtl_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dtl_pkg::t_out  o_out_data
);

    dtl_pkg::t_ctl  w_ctl;
    dtl_pkg::t_stat w_stat;

    dtl_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl),
        .o_in_ready (o_in_ready)
    );

    dtl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_in_data   (i_in_data),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/dtl_ucode_rom.sv
// Microprogram store: one control word per sequencer step.
module dtl_ucode_rom (
    input  dtl_pkg::t_step  i_step,
    output dtl_pkg::t_uword o_uword
);

    always_comb begin
        case (i_step)
            dtl_pkg::STEP_IDLE: begin
                o_uword = '{dtl_pkg::OP_IDLE, dtl_pkg::COND_IN_VALID,
                            dtl_pkg::STEP_PREP, dtl_pkg::STEP_IDLE};
            end
            dtl_pkg::STEP_PREP: begin
                o_uword = '{dtl_pkg::OP_PREP, dtl_pkg::COND_ALWAYS,
                            dtl_pkg::STEP_ID, dtl_pkg::STEP_ID};
            end
            dtl_pkg::STEP_ID: begin
                o_uword = '{dtl_pkg::OP_ID, dtl_pkg::COND_SHORT_TAG,
                            dtl_pkg::STEP_LENHDR, dtl_pkg::STEP_TAG};
            end
            dtl_pkg::STEP_TAG: begin
                o_uword = '{dtl_pkg::OP_TAG, dtl_pkg::COND_IDX_ZERO,
                            dtl_pkg::STEP_LENHDR, dtl_pkg::STEP_TAG};
            end
            dtl_pkg::STEP_LENHDR: begin
                o_uword = '{dtl_pkg::OP_LENHDR, dtl_pkg::COND_SHORT_LEN,
                            dtl_pkg::STEP_SWITCH, dtl_pkg::STEP_LENBYTE};
            end
            dtl_pkg::STEP_LENBYTE: begin
                o_uword = '{dtl_pkg::OP_LENBYTE, dtl_pkg::COND_IDX_ZERO,
                            dtl_pkg::STEP_SWITCH, dtl_pkg::STEP_LENBYTE};
            end
            dtl_pkg::STEP_SWITCH: begin
                o_uword = '{dtl_pkg::OP_SWITCH, dtl_pkg::COND_OUTER,
                            dtl_pkg::STEP_ID, dtl_pkg::STEP_IDLE};
            end
            default: begin
                o_uword = '{dtl_pkg::OP_IDLE, dtl_pkg::COND_ALWAYS,
                            dtl_pkg::STEP_IDLE, dtl_pkg::STEP_IDLE};
            end
        endcase
    end

endmodule

// File: rtl/dtl_sequencer.sv
// Step counter with conditional branching over the microprogram.
module dtl_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dtl_pkg::t_stat     i_stat,
    output dtl_pkg::t_ctl      o_ctl,
    output logic               o_in_ready
);

    dtl_pkg::t_step  r_step;
    dtl_pkg::t_step  n_step;
    dtl_pkg::t_uword w_uword;
    logic            w_cond;
    logic            w_emit;
    logic            w_fire;

    dtl_ucode_rom u_rom (
        .i_step  (r_step),
        .o_uword (w_uword)
    );

    always_comb begin
        case (w_uword.cond)
            dtl_pkg::COND_ALWAYS:    w_cond = 1'b1;
            dtl_pkg::COND_IN_VALID:  w_cond = i_in_valid;
            dtl_pkg::COND_SHORT_TAG: w_cond = i_stat.short_tag;
            dtl_pkg::COND_IDX_ZERO:  w_cond = i_stat.idx_zero;
            dtl_pkg::COND_SHORT_LEN: w_cond = i_stat.short_len;
            dtl_pkg::COND_OUTER:     w_cond = i_stat.outer;
            default:                 w_cond = 1'b0;
        endcase
    end

    assign w_emit = (w_uword.op == dtl_pkg::OP_ID) || (w_uword.op == dtl_pkg::OP_TAG) ||
                    (w_uword.op == dtl_pkg::OP_LENHDR) ||
                    (w_uword.op == dtl_pkg::OP_LENBYTE);

    // Hold the step while a byte waits for the output register.
    assign w_fire = (w_uword.op == dtl_pkg::OP_IDLE) ? i_in_valid
                                                     : !(w_emit && i_stat.out_busy);

    always_comb begin
        n_step = r_step;
        if (w_fire) begin
            n_step = w_cond ? w_uword.tgt_t : w_uword.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dtl_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.op   = w_uword.op;
    assign o_ctl.fire = w_fire;
    assign o_in_ready = (w_uword.op == dtl_pkg::OP_IDLE);

endmodule

// File: rtl/dtl_datapath.sv
// Field registers, header registers, byte formatting and output register.
module dtl_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dtl_pkg::t_ctl   i_ctl,
    input  dtl_pkg::t_in    i_in_data,
    output dtl_pkg::t_stat  o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dtl_pkg::t_out   o_out_data
);

    dtl_pkg::t_in                   r_in,    n_in;
    logic [1:0]                     r_hcls,  n_hcls;
    logic                           r_hcons, n_hcons;
    logic [dtl_pkg::TagW-1:0]       r_htag,  n_htag;
    logic [dtl_pkg::HlenW-1:0]      r_hlen,  n_hlen;
    logic [dtl_pkg::IdxW-1:0]       r_idx,   n_idx;
    logic                           r_outer, n_outer;
    logic                           r_ovalid, n_ovalid;
    dtl_pkg::t_out                  r_odata, n_odata;

    logic [1:0]                     w_icls;
    logic [dtl_pkg::TagW-1:0]       w_itag;
    logic [dtl_pkg::HlenW-1:0]      w_ilen;
    logic [dtl_pkg::NiW-1:0]        w_ni;
    logic [dtl_pkg::HlenW-1:0]      w_olen;
    logic                           w_ishort_tag;
    logic                           w_ishort_len;
    logic                           w_short_tag;
    logic                           w_short_len;
    logic [dtl_pkg::IdxW-1:0]       w_grp;
    logic [dtl_pkg::IdxW-1:0]       w_nb;
    logic [7:0]                     w_byte;
    logic                           w_last;
    logic                           w_emit;

    // Inner header after any implicit override.
    assign w_icls = (r_in.tag_mode == dtl_pkg::MODE_IMPLICIT) ? dtl_pkg::CLASS_CONTEXT
                                                              : r_in.tag_class;
    assign w_itag = (r_in.tag_mode == dtl_pkg::MODE_IMPLICIT) ? r_in.override_tag
                                                              : r_in.tag_number;
    assign w_ilen = {1'b0, r_in.content_length};

    assign w_ishort_tag = (w_itag <= dtl_pkg::TAG_SHORT_MAX);
    assign w_ishort_len = ~|w_ilen[dtl_pkg::HlenW-1:7];

    always_comb begin
        w_ni = dtl_pkg::NiW'(1);
        if (!w_ishort_tag) begin
            w_ni = w_ni + {1'b0, dtl_pkg::tag_groups(w_itag)};
        end
        if (w_ishort_len) begin
            w_ni = w_ni + dtl_pkg::NiW'(1);
        end else begin
            w_ni = w_ni + dtl_pkg::NiW'(1) + {1'b0, dtl_pkg::len_bytes(w_ilen)};
        end
    end

    assign w_olen = w_ilen + dtl_pkg::HlenW'(w_ni);

    // Current header.
    assign w_short_tag = (r_htag <= dtl_pkg::TAG_SHORT_MAX);
    assign w_short_len = ~|r_hlen[dtl_pkg::HlenW-1:7];
    assign w_grp       = dtl_pkg::tag_groups(r_htag);
    assign w_nb        = dtl_pkg::len_bytes(r_hlen);

    always_comb begin
        w_byte = 8'h00;
        w_emit = 1'b0;
        case (i_ctl.op)
            dtl_pkg::OP_ID: begin
                w_emit = 1'b1;
                w_byte = {r_hcls, r_hcons, w_short_tag ? r_htag[4:0] : dtl_pkg::TAG_LONG_ID};
            end
            dtl_pkg::OP_TAG: begin
                w_emit = 1'b1;
                w_byte = dtl_pkg::tag_byte(r_htag, r_idx);
            end
            dtl_pkg::OP_LENHDR: begin
                w_emit = 1'b1;
                w_byte = w_short_len ? r_hlen[7:0] : (dtl_pkg::LEN_LONG_FLAG | {5'b00000, w_nb});
            end
            dtl_pkg::OP_LENBYTE: begin
                w_emit = 1'b1;
                w_byte = dtl_pkg::len_byte(r_hlen, r_idx);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    assign w_last = !r_outer &&
                    (((i_ctl.op == dtl_pkg::OP_LENHDR) && w_short_len) ||
                     ((i_ctl.op == dtl_pkg::OP_LENBYTE) && (r_idx == '0)));

    always_comb begin
        n_in     = r_in;
        n_hcls   = r_hcls;
        n_hcons  = r_hcons;
        n_htag   = r_htag;
        n_hlen   = r_hlen;
        n_idx    = r_idx;
        n_outer  = r_outer;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        if (i_ctl.fire) begin
            case (i_ctl.op)
                dtl_pkg::OP_IDLE: begin
                    n_in = i_in_data;
                end
                dtl_pkg::OP_PREP: begin
                    if (r_in.tag_mode == dtl_pkg::MODE_EXPLICIT) begin
                        n_hcls  = dtl_pkg::CLASS_CONTEXT;
                        n_hcons = 1'b1;
                        n_htag  = r_in.override_tag;
                        n_hlen  = w_olen;
                        n_outer = 1'b1;
                    end else begin
                        n_hcls  = w_icls;
                        n_hcons = r_in.constructed;
                        n_htag  = w_itag;
                        n_hlen  = w_ilen;
                        n_outer = 1'b0;
                    end
                end
                dtl_pkg::OP_ID: begin
                    n_idx = w_grp - dtl_pkg::IdxW'(1);
                end
                dtl_pkg::OP_TAG: begin
                    n_idx = r_idx - dtl_pkg::IdxW'(1);
                end
                dtl_pkg::OP_LENHDR: begin
                    n_idx = w_nb - dtl_pkg::IdxW'(1);
                end
                dtl_pkg::OP_LENBYTE: begin
                    n_idx = r_idx - dtl_pkg::IdxW'(1);
                end
                dtl_pkg::OP_SWITCH: begin
                    // Outer header done: advance to the inner one.
                    if (r_outer) begin
                        n_hcls  = w_icls;
                        n_hcons = r_in.constructed;
                        n_htag  = w_itag;
                        n_hlen  = w_ilen;
                        n_outer = 1'b0;
                    end
                end
                default: begin
                    n_idx = r_idx;
                end
            endcase

            if (w_emit) begin
                n_ovalid            = 1'b1;
                n_odata.header_byte = w_byte;
                n_odata.last_byte   = w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_outer  <= n_outer;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_hcls  <= n_hcls;
        r_hcons <= n_hcons;
        r_htag  <= n_htag;
        r_hlen  <= n_hlen;
        r_idx   <= n_idx;
        r_odata <= n_odata;
    end

    assign o_stat.short_tag = w_short_tag;
    assign o_stat.short_len = w_short_len;
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.outer     = r_outer;
    assign o_stat.out_busy  = r_ovalid && !i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

// File: rtl/dtl_checker.sv
// Port-level checks for the DER header encoder and their binding to the top level.
module dtl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input dtl_pkg::t_in   i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input dtl_pkg::t_out  o_out_data
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // One element at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after an accept");

    // While idle, only the final word of the previous element may be pending.
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_data.last_byte)
        else $error("non-final word pending while idle");

    // A new word never appears while the encoder is idle.
    a_new_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready)
        else $error("word produced while idle");

endmodule

bind der_tag_length_header_encoder_top dtl_checker u_chk (.*);
